// ===== hw/rtl/wfm_pkg.sv =====
// Package for the wavetable FM sound channel.
// Holds state codes, command codes, bus addresses and envelope helpers.
// No dependencies.
`default_nettype none
package wfm_pkg;

   localparam int WAVE_ENTRIES = 64;

   typedef enum logic [10:0] {
      S_IDLE = 11'b000_0000_0001,
      S_EXEC = 11'b000_0000_0010,
      S_RDW  = 11'b000_0000_0100,
      S_T1   = 11'b000_0000_1000,
      S_T2   = 11'b000_0001_0000,
      S_T3   = 11'b000_0010_0000,
      S_T4   = 11'b000_0100_0000,
      S_T5   = 11'b000_1000_0000,
      S_T6   = 11'b001_0000_0000,
      S_T7   = 11'b010_0000_0000,
      S_DONE = 11'b100_0000_0000
   } state_type;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   localparam logic [15:0] ADDR_WAVE_LO = 16'h4040;
   localparam logic [15:0] ADDR_WAVE_HI = 16'h407F;
   localparam logic [15:0] ADDR_CTRL_LO = 16'h4080;
   localparam logic [15:0] ADDR_CTRL_HI = 16'h408F;
   localparam logic [15:0] ADDR_STAT_C  = 16'h4090;
   localparam logic [15:0] ADDR_STAT_M  = 16'h4092;

   // low nibble of control registers
   localparam logic [3:0] REG_ENV_C   = 4'd0;
   localparam logic [3:0] REG_FLO_C   = 4'd2;
   localparam logic [3:0] REG_FHI_C   = 4'd3;
   localparam logic [3:0] REG_ENV_M   = 4'd4;
   localparam logic [3:0] REG_BIAS    = 4'd5;
   localparam logic [3:0] REG_FLO_M   = 4'd6;
   localparam logic [3:0] REG_FHI_M   = 4'd7;
   localparam logic [3:0] REG_MODPUSH = 4'd8;
   localparam logic [3:0] REG_LEVEL   = 4'd9;
   localparam logic [3:0] REG_PERIOD  = 4'd10;

   // csr register indexes
   localparam logic [2:0] CSR_PSS = 3'd0;
   localparam logic [2:0] CSR_ESS = 3'd1;
   localparam logic [2:0] CSR_LG0 = 3'd2;
   localparam logic [2:0] CSR_LG1 = 3'd3;
   localparam logic [2:0] CSR_LG2 = 3'd4;
   localparam logic [2:0] CSR_LG3 = 3'd5;

   localparam logic [2:0]  MOD_RESET_CODE = 3'd4;
   localparam logic signed [11:0] M_HI   = 12'sd193;
   localparam logic signed [11:0] M_LO   = -12'sd64;
   localparam logic signed [11:0] M_WRAP = 12'sd258;
   localparam logic signed [11:0] M_ADD  = 12'sd256;
   localparam logic [5:0]  GAIN_MAX   = 6'h1f;
   localparam logic [5:0]  VOL_MAX    = 6'h20;
   localparam logic [19:0] PERIOD_RST = 20'hE8000;
   localparam logic [11:0] PSS_RST    = 12'd1023;
   localparam logic [11:0] ESS_RST    = 12'd511;

   typedef struct packed {
      logic [1:0] mode;
      logic [5:0] rate;
      logic [7:0] count;
      logic [5:0] gain;
   } env_type;

   function automatic logic signed [6:0] bias_delta(input logic [2:0] v);
      logic signed [6:0] d;
      case (v)
         3'd1:    d = 7'sd1;
         3'd2:    d = 7'sd2;
         3'd3:    d = 7'sd4;
         3'd5:    d = -7'sd4;
         3'd6:    d = -7'sd2;
         3'd7:    d = -7'sd1;
         default: d = 7'sd0;
      endcase
      return d;
   endfunction

   function automatic env_type env_step(input env_type e);
      env_type r;
      r = e;
      if (!e.mode[1]) begin
         r.count = e.count + 8'd1;
         if (r.count > {2'b00, e.rate}) begin
            r.count = 8'd0;
            if (e.mode[0]) begin
               if (e.gain < GAIN_MAX) r.gain = e.gain + 6'd1;
            end else if (e.gain != 6'd0) begin
               r.gain = e.gain - 6'd1;
            end
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/wfm_req_if.sv =====
// Input channel of the sound channel: valid/ready plus command payload.
// Standalone, no dependencies.
`default_nettype none
interface wfm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [15:0] address;
   logic [7:0]  write_data;
   modport source (output valid, output cmd, output address, output write_data, input ready);
   modport sink (input valid, input cmd, input address, input write_data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/wfm_rsp_if.sv =====
// Result channel of the sound channel: valid/ready plus read data and sample.
// Standalone, no dependencies.
`default_nettype none
interface wfm_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         read_data;
   logic signed [23:0] sample;
   modport source (output valid, output read_data, output sample, input ready);
   modport sink (input valid, input read_data, input sample, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/wavetable_fm_sound_channel.sv =====
// Wavetable FM sound channel top level; uses wfm_pkg, wfm_req_if, wfm_rsp_if, wfm_ram.
// Steps: EXEC then DONE for write, unused command or other read; a wave read adds RDW,
// and a tick runs T1 to T7 before DONE, using one shared 22x22 multiplier.
// Throughput: one item at a time; ready again the cycle after the result is registered,
// and an item that finishes while the previous result still waits holds in its last step.
// Reset: synchronous; wavetable and modulation table return to reset contents at once
// through per-entry valid bits, no clearing pass.
`default_nettype none
module wavetable_fm_sound_channel
   import wfm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   wfm_req_if.sink          req_ch,
   wfm_rsp_if.source        rsp_ch,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   localparam int IW = $clog2(WAVE_ENTRIES);
   localparam int PAIRS = WAVE_ENTRIES / 2;
   localparam int PW = $clog2(PAIRS);

   state_type state_ff, state_in;

   logic [11:0] pss_ff, ess_ff;
   logic [20:0] lg_ff [4];

   logic [1:0]  cmd_ff;
   logic [15:0] addr_ff;
   logic [7:0]  wdata_ff;

   logic [WAVE_ENTRIES-1:0] wv_valid_ff;
   logic [PAIRS-1:0]        mt_valid_ff;
   logic [PW-1:0]           mt_head_ff;
   logic                    wv_rvalid_ff, wv_rmsb_ff, mt_rvalid_ff;

   logic [31:0] cphase_ff, mphase_ff, step_ff, accum_ff;
   logic [11:0] cfreq_ff, mfreq_ff;
   logic signed [5:0] csample_ff;
   logic signed [6:0] bias_ff;
   env_type cenv_ff, menv_ff;
   logic chalt_ff, mhalt_ff, hold_ff, ehalt_ff, crossed_ff, env_due_ff;
   logic [1:0]  lsel_ff;
   logic [19:0] period_ff;

   logic [7:0]         res_rd_ff;
   logic signed [23:0] res_smp_ff;
   logic               rsp_valid_ff;
   logic [7:0]         rsp_rd_ff;
   logic signed [23:0] rsp_smp_ff;

   logic signed [43:0] prod_ff;
   logic signed [21:0] mul_a, mul_b;

   logic          wv_we;
   logic [IW-1:0] wv_waddr, wv_raddr;
   logic [5:0]    wv_wdata, wv_rdata, wv_val;
   logic          mt_we;
   logic [PW-1:0] mt_raddr;
   logic [2:0]    mt_rdata, mt_val;

   logic cfg_wr;
   logic req_acc;

   assign req_acc = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.read_data = rsp_rd_ff;
   assign rsp_ch.sample = rsp_smp_ff;
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   wfm_ram #(.WIDTH(6), .DEPTH(WAVE_ENTRIES)) u_wave_ram (
      .clock(clock), .we(wv_we), .waddr(wv_waddr), .wdata(wv_wdata),
      .raddr(wv_raddr), .rdata(wv_rdata)
   );

   wfm_ram #(.WIDTH(3), .DEPTH(PAIRS)) u_mod_ram (
      .clock(clock), .we(mt_we), .waddr(mt_head_ff), .wdata(wdata_ff[2:0]),
      .raddr(mt_raddr), .rdata(mt_rdata)
   );

   assign wv_val = wv_rvalid_ff ? wv_rdata : (wv_rmsb_ff ? 6'd0 : 6'd63);
   assign mt_val = mt_rvalid_ff ? mt_rdata : 3'd0;

   always_comb begin
      case (paddr[4:2])
         CSR_PSS: prdata = {20'd0, pss_ff};
         CSR_ESS: prdata = {20'd0, ess_ff};
         CSR_LG0: prdata = {11'd0, lg_ff[0]};
         CSR_LG1: prdata = {11'd0, lg_ff[1]};
         CSR_LG2: prdata = {11'd0, lg_ff[2]};
         CSR_LG3: prdata = {11'd0, lg_ff[3]};
         default: prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pss_ff <= PSS_RST;
         ess_ff <= ESS_RST;
         for (int i = 0; i < 4; i++) lg_ff[i] <= 21'd0;
      end else if (cfg_wr) begin
         case (paddr[4:2])
            CSR_PSS: pss_ff <= pwdata[11:0];
            CSR_ESS: ess_ff <= pwdata[11:0];
            CSR_LG0: lg_ff[0] <= pwdata[20:0];
            CSR_LG1: lg_ff[1] <= pwdata[20:0];
            CSR_LG2: lg_ff[2] <= pwdata[20:0];
            CSR_LG3: lg_ff[3] <= pwdata[20:0];
            default: ;
         endcase
      end
   end

   // tick datapath terms
   logic [26:0]        msum;
   logic [31:0]        mphase_new;
   logic signed [6:0]  bias_next;
   logic signed [12:0] bm_prod;
   logic signed [11:0] m1, m2;
   logic signed [20:0] q;
   logic signed [17:0] nf;
   logic [5:0]         vol;
   logic [31:0]        accum_sum;
   logic               wave_hit, ctrl_hit;

   assign wave_hit = (addr_ff >= ADDR_WAVE_LO) && (addr_ff <= ADDR_WAVE_HI);
   assign ctrl_hit = (addr_ff >= ADDR_CTRL_LO) && (addr_ff <= ADDR_CTRL_HI);
   assign msum = {1'b0, mphase_ff[25:0]} + {3'd0, prod_ff[23:0]};
   assign mphase_new = mphase_ff + {8'd0, prod_ff[23:0]};
   assign mt_raddr = mt_head_ff + mphase_new[31:32-PW];

   always_comb begin
      if (crossed_ff && !mhalt_ff) begin
         if (mt_val == MOD_RESET_CODE) bias_next = 7'sd0;
         else bias_next = bias_ff + bias_delta(mt_val);
      end else begin
         bias_next = bias_ff;
      end
      bm_prod = prod_ff[12:0];
      m1 = 12'(bm_prod >>> 4);
      m2 = m1;
      if (m1[3:0] != 4'd0) m2 = m1 + (bias_ff < 0 ? -12'sd1 : 12'sd2);
      if (m2 > M_HI) m2 = m2 - M_WRAP;
      if (m2 < M_LO) m2 = m2 + M_ADD;
      q = 21'(prod_ff >>> 6);
      nf = $signed({6'd0, cfreq_ff}) + 18'(q);
      if (nf < 0) nf = 18'sd0;
      vol = (cenv_ff.gain > VOL_MAX) ? VOL_MAX : cenv_ff.gain;
      accum_sum = accum_ff + {20'd0, ess_ff};
   end

   always_comb begin
      mul_a = 22'sd0;
      mul_b = 22'sd0;
      wv_raddr = cphase_ff[31:32-IW];
      case (state_ff)
         S_EXEC: begin
            mul_a = $signed({10'd0, mfreq_ff});
            mul_b = $signed({10'd0, pss_ff});
            if (cmd_ff == CMD_READ) wv_raddr = addr_ff[IW-1:0];
         end
         S_T2: begin
            mul_a = 22'(bias_next);
            mul_b = $signed({16'd0, menv_ff.gain});
         end
         S_T3: begin
            mul_a = 22'(m2);
            mul_b = $signed({10'd0, cfreq_ff});
         end
         S_T4: begin
            mul_a = mhalt_ff ? $signed({10'd0, cfreq_ff}) : $signed({4'd0, nf});
            mul_b = $signed({10'd0, pss_ff});
         end
         S_T5: begin
            mul_a = 22'(csample_ff);
            mul_b = $signed({16'd0, vol});
         end
         S_T6: begin
            mul_a = 22'($signed(prod_ff[10:0]));
            mul_b = $signed({1'b0, lg_ff[lsel_ff]});
         end
         default: ;
      endcase
   end

   assign wv_we = (state_ff == S_EXEC) && (cmd_ff == CMD_WRITE) && wave_hit;
   assign wv_waddr = addr_ff[IW-1:0];
   assign wv_wdata = wdata_ff[5:0];
   assign mt_we = (state_ff == S_EXEC) && (cmd_ff == CMD_WRITE) && ctrl_hit &&
                  (addr_ff[3:0] == REG_MODPUSH) && mhalt_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_acc) state_in = S_EXEC;
         S_EXEC: begin
            if (cmd_ff == CMD_TICK) state_in = S_T1;
            else if (cmd_ff == CMD_READ && wave_hit) state_in = S_RDW;
            else state_in = S_DONE;
         end
         S_RDW:  state_in = S_DONE;
         S_T1:   state_in = S_T2;
         S_T2:   state_in = S_T3;
         S_T3:   state_in = S_T4;
         S_T4:   state_in = S_T5;
         S_T5:   state_in = S_T6;
         S_T6:   state_in = S_T7;
         S_T7:   state_in = S_DONE;
         S_DONE: if (!rsp_valid_ff || rsp_ch.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      wv_rvalid_ff <= wv_valid_ff[wv_raddr];
      wv_rmsb_ff <= wv_raddr[IW-1];
      mt_rvalid_ff <= mt_valid_ff[mt_raddr];
      if (req_acc) begin
         cmd_ff <= req_ch.cmd;
         addr_ff <= req_ch.address;
         wdata_ff <= req_ch.write_data;
      end
      if (state_ff == S_T5) step_ff <= prod_ff[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wv_valid_ff <= '0;
         mt_valid_ff <= '0;
         mt_head_ff <= '0;
         cphase_ff <= 32'd0;
         mphase_ff <= 32'd0;
         accum_ff <= 32'd0;
         cfreq_ff <= 12'd0;
         mfreq_ff <= 12'd0;
         csample_ff <= 6'sd0;
         bias_ff <= 7'sd0;
         cenv_ff <= '0;
         menv_ff <= '0;
         chalt_ff <= 1'b0;
         mhalt_ff <= 1'b0;
         hold_ff <= 1'b0;
         ehalt_ff <= 1'b1;
         crossed_ff <= 1'b0;
         env_due_ff <= 1'b0;
         lsel_ff <= 2'd0;
         period_ff <= PERIOD_RST;
         res_rd_ff <= 8'd0;
         res_smp_ff <= 24'sd0;
         rsp_valid_ff <= 1'b0;
         rsp_rd_ff <= 8'd0;
         rsp_smp_ff <= 24'sd0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ch.ready)) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_EXEC: begin
               res_smp_ff <= 24'sd0;
               if (cmd_ff == CMD_READ && addr_ff == ADDR_STAT_C)
                  res_rd_ff <= {2'b01, cenv_ff.gain};
               else if (cmd_ff == CMD_READ && addr_ff == ADDR_STAT_M)
                  res_rd_ff <= {2'b01, menv_ff.gain};
               else
                  res_rd_ff <= 8'd0;
               if (wv_we) wv_valid_ff[wv_waddr] <= 1'b1;
               if (mt_we) begin
                  mt_valid_ff[mt_head_ff] <= 1'b1;
                  mt_head_ff <= mt_head_ff + PW'(1);
               end
               if (cmd_ff == CMD_WRITE && ctrl_hit) begin
                  case (addr_ff[3:0])
                     REG_ENV_C, REG_ENV_M: begin
                        if (addr_ff[2]) begin
                           menv_ff.mode <= wdata_ff[7:6];
                           if (wdata_ff[7]) menv_ff.gain <= wdata_ff[5:0];
                           else menv_ff.rate <= wdata_ff[5:0];
                        end else begin
                           cenv_ff.mode <= wdata_ff[7:6];
                           if (wdata_ff[7]) cenv_ff.gain <= wdata_ff[5:0];
                           else cenv_ff.rate <= wdata_ff[5:0];
                        end
                     end
                     REG_BIAS: begin
                        bias_ff <= wdata_ff[6:0];
                        mphase_ff <= 32'd0;
                     end
                     REG_FLO_C: cfreq_ff[7:0] <= wdata_ff;
                     REG_FLO_M: mfreq_ff[7:0] <= wdata_ff;
                     REG_FHI_C: begin
                        ehalt_ff <= wdata_ff[6];
                        cfreq_ff[11:8] <= wdata_ff[3:0];
                        chalt_ff <= wdata_ff[7];
                        if (wdata_ff[7]) cphase_ff <= 32'd0;
                     end
                     REG_FHI_M: begin
                        mfreq_ff[11:8] <= wdata_ff[3:0];
                        mhalt_ff <= wdata_ff[7];
                        if (wdata_ff[7]) mphase_ff <= 32'd0;
                     end
                     REG_LEVEL: begin
                        lsel_ff <= wdata_ff[1:0];
                        hold_ff <= wdata_ff[7];
                     end
                     REG_PERIOD: period_ff <= {wdata_ff, 12'd0};
                     default: ;
                  endcase
               end
            end
            S_RDW: res_rd_ff <= {2'b00, wv_val};
            S_T1: begin
               if (!chalt_ff && !hold_ff) csample_ff <= {~wv_val[5], wv_val[4:0]};
               if (!mhalt_ff) mphase_ff <= mphase_new;
               crossed_ff <= msum[26];
            end
            S_T2: bias_ff <= bias_next;
            S_T5: begin
               env_due_ff <= !ehalt_ff && (period_ff != 20'd0);
               if (!ehalt_ff && (period_ff != 20'd0)) accum_ff <= accum_sum;
            end
            S_T6: begin
               if (env_due_ff && (accum_ff >= {12'd0, period_ff})) begin
                  accum_ff <= accum_ff - {12'd0, period_ff};
                  menv_ff <= env_step(menv_ff);
                  cenv_ff <= env_step(cenv_ff);
               end
            end
            S_T7: begin
               res_smp_ff <= (cfreq_ff != 12'd0) ? prod_ff[31:8] : 24'sd0;
               cphase_ff <= cphase_ff + step_ff;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_rd_ff <= res_rd_ff;
                  rsp_smp_ff <= res_smp_ff;
               end
            end
            default: ;
         endcase
      end
   end

`ifndef SYNTH
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_ch.ready)
      else $error("input accepted while an item is in progress");
   a_mod_phase_halted: assert property (@(posedge clock) disable iff (reset)
      (mhalt_ff && state_ff == S_T1) |=> $stable(mphase_ff))
      else $error("modulator phase moved while halted");
   a_result_only_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the done step");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/wfm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module wfm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking bench for wavetable_fm_sound_channel: drives bus writes, reads and
// sample ticks over valid/ready channels and compares each result item with an
// in-bench model. Depends on wfm_pkg, wfm_req_if, wfm_rsp_if and the RTL.
`timescale 1ns / 100ps
module tb;
   import wfm_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_ITEMS = 285;

   typedef struct {
      logic [1:0]  cmd;
      logic [15:0] addr;
      logic [7:0]  data;
   } bus_item_type;

   typedef struct {
      logic [7:0]  rd;
      logic [23:0] smp;
   } chan_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel, penable, pwrite;
   logic [4:0] paddr;
   logic [31:0] pwdata, prdata;
   logic pready;

   wfm_req_if req_ch ();
   wfm_rsp_if rsp_ch ();

   wavetable_fm_sound_channel uut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // channel model state
   logic [11:0] m_pss, m_ess;
   logic [20:0] m_lgain [4];
   logic [5:0]  m_wave [64];
   logic [2:0]  m_modtab [64];
   logic [31:0] m_cphase, m_mphase, m_accum;
   logic [11:0] m_cfreq, m_mfreq;
   int          m_csample, m_bias;
   env_type     m_cenv, m_menv;
   logic        m_chalt, m_mhalt, m_hold, m_envhalt;
   logic [1:0]  m_lsel;
   logic [19:0] m_period;
   int          delta_tbl [8] = '{0, 1, 2, 4, 0, -4, -2, -1};

   bus_item_type pending [$];
   chan_out_type due_q [$];
   bus_item_type cur;
   int          gap_left, stall_left, hold_left;
   logic        hold_done, calm;
   int          accepted_n, errors, cycles, n_ticks, n_writes, n_reads;

   function automatic env_type env_advance(env_type e);
      env_type r;
      r = e;
      if (!e.mode[1]) begin
         r.count = e.count + 8'd1;
         if (r.count > {2'b00, e.rate}) begin
            r.count = 8'd0;
            if (e.mode[0]) begin
               if (e.gain < 6'h1f) r.gain = e.gain + 6'd1;
            end else if (e.gain != 0) begin
               r.gain = e.gain - 6'd1;
            end
         end
      end
      return r;
   endfunction

   task automatic model_reset();
      m_pss = PSS_RST;
      m_ess = ESS_RST;
      for (int i = 0; i < 4; i++) m_lgain[i] = '0;
      for (int i = 0; i < 64; i++) begin
         m_wave[i] = (i < 32) ? 6'd63 : 6'd0;
         m_modtab[i] = '0;
      end
      m_cphase = 0; m_mphase = 0; m_accum = 0;
      m_cfreq = 0; m_mfreq = 0; m_csample = 0; m_bias = 0;
      m_cenv = '0; m_menv = '0;
      m_chalt = 0; m_mhalt = 0; m_hold = 0; m_envhalt = 1;
      m_lsel = 0;
      m_period = PERIOD_RST;
   endtask

   task automatic bus_store(logic [15:0] a, logic [7:0] v);
      logic is_mod;
      if (a >= ADDR_WAVE_LO && a <= ADDR_WAVE_HI) begin
         m_wave[a[5:0]] = v[5:0];
      end else if (a >= ADDR_CTRL_LO && a <= ADDR_CTRL_HI) begin
         is_mod = a[2];
         case (a[3:0])
            REG_ENV_C, REG_ENV_M: begin
               if (is_mod) begin
                  m_menv.mode = v[7:6];
                  if (v[7]) m_menv.gain = v[5:0]; else m_menv.rate = v[5:0];
               end else begin
                  m_cenv.mode = v[7:6];
                  if (v[7]) m_cenv.gain = v[5:0]; else m_cenv.rate = v[5:0];
               end
            end
            REG_BIAS: begin
               m_bias = int'(v[5:0]) - (v[6] ? 64 : 0);
               m_mphase = 0;
            end
            REG_FLO_C: m_cfreq[7:0] = v;
            REG_FLO_M: m_mfreq[7:0] = v;
            REG_FHI_C: begin
               m_envhalt = v[6];
               m_cfreq[11:8] = v[3:0];
               m_chalt = v[7];
               if (v[7]) m_cphase = 0;
            end
            REG_FHI_M: begin
               m_mfreq[11:8] = v[3:0];
               m_mhalt = v[7];
               if (v[7]) m_mphase = 0;
            end
            REG_MODPUSH: begin
               if (m_mhalt) begin
                  for (int i = 0; i < 62; i++) m_modtab[i] = m_modtab[i+2];
                  m_modtab[62] = v[2:0];
                  m_modtab[63] = v[2:0];
               end
            end
            REG_LEVEL: begin
               m_lsel = v[1:0];
               m_hold = v[7];
            end
            REG_PERIOD: m_period = {v, 12'h000};
            default: ;
         endcase
      end
   endtask

   function automatic logic [7:0] bus_fetch(logic [15:0] a);
      if (a >= ADDR_WAVE_LO && a <= ADDR_WAVE_HI) return {2'b00, m_wave[a[5:0]]};
      if (a == ADDR_STAT_C) return {2'b01, m_cenv.gain};
      if (a == ADDR_STAT_M) return {2'b01, m_menv.gain};
      return 8'h00;
   endfunction

   task automatic sample_tick(output logic [23:0] smp);
      logic [31:0] cstep, adv;
      logic        crossed;
      logic [2:0]  v;
      int          m, nf, vol;
      longint      acc;
      if (!m_chalt && !m_hold) m_csample = int'(m_wave[m_cphase[31:26]]) - 32;
      if (m_mhalt) begin
         cstep = m_cfreq * m_pss;
      end else begin
         adv = m_mfreq * m_pss;
         crossed = (longint'(m_mphase[25:0]) + longint'(adv)) > 64'h3ffffff;
         m_mphase = m_mphase + adv;
         if (crossed) begin
            v = m_modtab[m_mphase[31:26]];
            if (v == MOD_RESET_CODE) begin
               m_bias = 0;
            end else begin
               m_bias = m_bias + delta_tbl[v];
               while (m_bias > 63) m_bias -= 128;
               while (m_bias < -64) m_bias += 128;
            end
         end
         m = (m_bias * int'(m_menv.gain)) >>> 4;
         if (m[3:0] != 0) m += (m_bias < 0) ? -1 : 2;
         if (m > int'(M_HI)) m -= int'(M_WRAP);
         if (m < int'(M_LO)) m += int'(M_ADD);
         m = (m * int'(m_cfreq)) >>> 6;
         nf = int'(m_cfreq) + m;
         if (nf < 0) nf = 0;
         cstep = nf * m_pss;
      end
      vol = (m_cenv.gain > VOL_MAX) ? int'(VOL_MAX) : int'(m_cenv.gain);
      acc = (longint'(m_csample) * vol * longint'(m_lgain[m_lsel])) >>> 8;
      if (!m_envhalt && m_period != 0) begin
         m_accum = m_accum + m_ess;
         if (m_accum >= m_period) begin
            m_accum = m_accum - m_period;
            m_menv = env_advance(m_menv);
            m_cenv = env_advance(m_cenv);
         end
      end
      m_cphase = m_cphase + cstep;
      smp = (m_cfreq != 0) ? acc[23:0] : 24'h0;
   endtask

   task automatic predict(bus_item_type it);
      chan_out_type r;
      r.rd = '0;
      r.smp = '0;
      case (it.cmd)
         CMD_WRITE: begin bus_store(it.addr, it.data); n_writes++; end
         CMD_READ:  begin r.rd = bus_fetch(it.addr); n_reads++; end
         CMD_TICK:  begin sample_tick(r.smp); n_ticks++; end
         default: ;
      endcase
      due_q.push_back(r);
   endtask

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   // driver
   always @(posedge clock) begin
      logic nv;
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left <= 0;
         accepted_n <= 0;
      end else begin
         nv = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            predict(cur);
            accepted_n <= accepted_n + 1;
            nv = 1'b0;
         end
         if (!nv) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
            end else if (pending.size() != 0) begin
               cur = pending.pop_front();
               req_ch.cmd <= cur.cmd;
               req_ch.address <= cur.addr;
               req_ch.write_data <= cur.data;
               nv = 1'b1;
               gap_left <= pick_gap();
            end
         end
         req_ch.valid <= nv;
      end
   end

   // monitor
   always @(posedge clock) begin
      chan_out_type w;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_q.size() == 0) begin
               report("unexpected item", {24'h0, rsp_ch.read_data}, 32'h0);
            end else begin
               w = due_q.pop_front();
               if (rsp_ch.read_data !== w.rd) report("read_data", rsp_ch.read_data, w.rd);
               if (rsp_ch.sample !== w.smp) report("sample", rsp_ch.sample, w.smp);
            end
         end
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            stall_left <= pick_gap();
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && accepted_n == 500) begin
         hold_left <= 300;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         CSR_PSS: m_pss = val[11:0];
         CSR_ESS: m_ess = val[11:0];
         CSR_LG0: m_lgain[0] = val[20:0];
         CSR_LG1: m_lgain[1] = val[20:0];
         CSR_LG2: m_lgain[2] = val[20:0];
         default: m_lgain[3] = val[20:0];
      endcase
   endtask

   task automatic add(logic [1:0] c, logic [15:0] a, logic [7:0] d);
      bus_item_type it;
      it.cmd = c; it.addr = a; it.data = d;
      pending.push_back(it);
   endtask

   task automatic add_random();
      int r;
      logic [15:0] a;
      logic [7:0] d;
      r = $urandom_range(0, 99);
      a = $urandom_range(0, 65535);
      d = $urandom_range(0, 255);
      if (r < 50) begin
         add(CMD_TICK, a, d);
      end else if (r < 80) begin
         if ($urandom_range(0, 3) == 0) a = ADDR_WAVE_LO + $urandom_range(0, 63);
         else a = ADDR_CTRL_LO + $urandom_range(0, 15);
         if (a[3:0] == REG_PERIOD && a[7] && $urandom_range(0, 1)) d = $urandom_range(0, 3);
         add(CMD_WRITE, a, d);
      end else if (r < 93) begin
         case ($urandom_range(0, 3))
            0: a = ADDR_STAT_C;
            1: a = ADDR_STAT_M;
            2: a = ADDR_WAVE_LO + $urandom_range(0, 63);
            default: ;
         endcase
         add(CMD_READ, a, d);
      end else begin
         add(2'($urandom_range(0, 3)), a, d);
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending.size() != 0 || req_ch.valid || due_q.size() != 0);
      repeat (12) @(posedge clock);
   endtask

   initial begin
      logic [31:0] cfg [4][6];
      req_ch.valid = 1'b0; req_ch.cmd = '0; req_ch.address = '0; req_ch.write_data = '0;
      rsp_ch.ready = 1'b0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      errors = 0; cycles = 0; n_ticks = 0; n_writes = 0; n_reads = 0; calm = 1'b0;
      cfg[0] = '{1023, 511, 1000, 200000, 2097151, 65536};
      cfg[1] = '{0, 0, 0, 0, 0, 0};
      cfg[2] = '{4095, 4095, 2097151, 2097151, 2097151, 2097151};
      cfg[3] = '{$urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 2097151),
                 $urandom_range(0, 2097151), $urandom_range(0, 2097151),
                 $urandom_range(0, 2097151)};
      model_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 4; p++) begin
         for (int i = 0; i < 6; i++) csr_write(3'(i), cfg[p][i]);
         calm = (p == 2);
         @(negedge clock);
         if (p == 0) begin
            add(CMD_TICK, 16'h0000, 8'h00);
            add(CMD_WRITE, 16'h4083, 8'h0F);
            add(CMD_WRITE, 16'h4082, 8'hFF);
            add(CMD_WRITE, 16'h4080, 8'hBF);
            add(CMD_WRITE, 16'h4089, 8'h83);
            add(CMD_WRITE, 16'h4040, 8'h00);
            add(CMD_WRITE, 16'h407F, 8'hFF);
            add(CMD_WRITE, 16'h4087, 8'h80);
            add(CMD_WRITE, 16'h4088, 8'h07);
            add(CMD_WRITE, 16'h4088, 8'h04);
            add(CMD_WRITE, 16'h4088, 8'hFB);
            add(CMD_WRITE, 16'h4085, 8'h40);
            add(CMD_WRITE, 16'h4086, 8'hFF);
            add(CMD_WRITE, 16'h4087, 8'h0F);
            add(CMD_WRITE, 16'h4084, 8'h7F);
            add(CMD_WRITE, 16'h4089, 8'h00);
            add(CMD_WRITE, 16'h408A, 8'h00);
            for (int i = 0; i < 3; i++) add(CMD_TICK, 16'hFFFF, 8'hFF);
            add(CMD_WRITE, 16'h408A, 8'h01);
            add(CMD_TICK, 16'h4090, 8'h00);
            add(CMD_READ, ADDR_STAT_C, 8'h00);
            add(CMD_READ, ADDR_STAT_M, 8'hFF);
            add(CMD_READ, ADDR_WAVE_HI, 8'h00);
            add(CMD_READ, 16'hFFFF, 8'h00);
            add(2'd3, 16'hABCD, 8'h5A);
            add(CMD_WRITE, 16'h0000, 8'hFF);
         end
         for (int i = 0; i < PHASE_ITEMS; i++) add_random();
         wait_drained();
      end
      repeat (20) @(posedge clock);
      while (due_q.size() != 0) begin
         void'(due_q.pop_front());
         report("missing item", 0, 0);
      end
      $display("covered %0d items: %0d ticks, %0d writes, %0d reads, 4 csr settings",
               accepted_n, n_ticks, n_writes, n_reads);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", errors);
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/wfm_pkg.sv
hw/rtl/wfm_req_if.sv
hw/rtl/wfm_rsp_if.sv
hw/rtl/wfm_ram.sv
hw/rtl/wavetable_fm_sound_channel.sv
dv/tb.sv
